[hdl/fph_pkg.sv]
// shared types, constants and state codes of the fit-policy heap allocator
package fph_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int GROW_BYTES   = 4096;
	localparam int MAX_CHUNKS   = 64;
	localparam int ARENA_BYTES  = 65536;

	localparam int IDX_W = $clog2(MAX_CHUNKS);
	localparam int CNT_W = IDX_W + 1;

	localparam logic       FN_ALLOC   = 1'b0;
	localparam logic       FN_FREE    = 1'b1;
	localparam logic [1:0] POL_FIRST  = 2'd0;
	localparam logic [1:0] POL_BEST   = 2'd1;
	localparam logic [1:0] POL_WORST  = 2'd2;
	localparam logic       REG_POLICY = 1'b0;
	localparam logic       REG_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_IGNORED  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CTX_GROW,
		CTX_FREE,
		CTX_TAKE
	} ctx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SLOT,
		S_GROW,
		S_MSCAN,
		S_MDEC,
		S_RM_RD,
		S_RM_WR,
		S_FRONT,
		S_PU_RD,
		S_PU_WR,
		S_PU_HEAD,
		S_MERGED,
		S_FSCAN,
		S_TAKE,
		S_COMMIT,
		S_USCAN,
		S_STATS,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] start;
		logic [16:0] len;
	} chunk_t;

	typedef struct packed {
		logic        sub;
		logic [17:0] a;
		logic [17:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        func;
		logic [15:0] req_bytes;
		logic [15:0] addr;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] granted;
		logic [16:0] free_bytes;
		logic [6:0]  chunks;
		logic [16:0] largest;
		logic [16:0] smallest;
	} result_t;

endpackage

[hdl/fph_alu.sv]
// shared add/subtract unit used by the arithmetic steps of the sequencer
module fph_alu (
	input  fph_pkg::alu_req_t op,
	output logic [17:0]       res
);
	import fph_pkg::*;

	assign res = op.sub ? (op.a - op.b) : (op.a + op.b);

endmodule

[hdl/fph_core.sv]
// sequencer, free and used chunk tables and statistics scan of the allocator
module fph_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic [1:0]        policy,
	input  logic [16:0]       limit,
	input  logic              req_valid,
	input  fph_pkg::request_t req,
	output logic              req_ready,
	output logic              res_valid,
	output fph_pkg::result_t  res,
	input  logic              res_ready
);
	import fph_pkg::*;

	state_t state_q, state_d;

	chunk_t fmem [MAX_CHUNKS];
	chunk_t umem [MAX_CHUNKS];
	chunk_t frd_q, urd_q, fwd, uwd;
	logic [IDX_W-1:0] fra, fwa, ura;
	logic fwe, uwe;

	logic [CNT_W-1:0] n_q, c_q;
	logic [16:0] heap_top_q, total_q, need_q;
	logic [MAX_CHUNKS-1:0] used_valid_q;
	logic pend_s1;
	logic [IDX_W-1:0] idx_s1, slot_q;
	logic [15:0] addr_q;
	status_t status_q;
	logic [15:0] granted_q;
	ctx_t ctx_q;

	logic [15:0] ins_s_q;
	logic [16:0] ins_l_q, add_q;
	logic [17:0] sl_q;
	logic front_vld_q, back_vld_q;
	logic [IDX_W-1:0] front_idx_q, back_idx_q;
	logic [15:0] front_start_q;
	logic [16:0] front_len_q, back_len_q;

	logic pick_vld_q;
	logic [IDX_W-1:0] pick_idx_q;
	logic [15:0] pick_start_q;
	logic [16:0] pick_len_q;

	logic [16:0] sum_q, lg_q, sm_q;
	logic [6:0] cnt_q;

	alu_req_t alu_op;
	logic [17:0] alu_res;

	logic scan_state, issue, scan_end, scan_entry;
	logic [CNT_W-1:0] scan_lim;
	logic m_front, m_back, f_fit, f_take, u_hit, s_ok, grow_bad, better;

	fph_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	// table storage, registered read
	always_ff @(posedge clk) begin
		if (fwe) fmem[fwa] <= fwd;
		frd_q <= fmem[fra];
		if (uwe) umem[slot_q] <= uwd;
		urd_q <= umem[ura];
	end

	// scan pipeline control
	always_comb begin
		scan_state = (state_q == S_MSCAN) || (state_q == S_FSCAN) ||
			(state_q == S_USCAN) || (state_q == S_STATS);
		scan_lim   = (state_q == S_USCAN) ? CNT_W'(MAX_CHUNKS) : n_q;
		issue      = scan_state && (c_q < scan_lim);
		scan_end   = scan_state && !issue && !pend_s1;
		scan_entry = (state_d != state_q) && (state_d == S_MSCAN || state_d == S_FSCAN ||
			state_d == S_USCAN || state_d == S_STATS);
	end

	// compare results of the entry under evaluation
	always_comb begin
		m_front  = pend_s1 && (alu_res == 18'(ins_s_q));
		m_back   = pend_s1 && !m_front && (18'(frd_q.start) == sl_q);
		f_fit    = pend_s1 && (frd_q.len >= need_q);
		better   = (policy == POL_BEST) ? (frd_q.len < pick_len_q) : (frd_q.len > pick_len_q);
		f_take   = f_fit && (!pick_vld_q || ((policy != POL_FIRST) && better));
		u_hit    = pend_s1 && used_valid_q[idx_s1] && (alu_res[15:0] == addr_q);
		s_ok     = pend_s1 && (frd_q.len >= 17'(HEADER_BYTES));
		grow_bad = (alu_res > 18'(limit)) || (alu_res > 18'(ARENA_BYTES));
	end

	// shared unit operand selection
	always_comb begin
		alu_op = '0;
		unique case (state_q)
			S_GROW:   alu_op = '{1'b0, 18'(heap_top_q), 18'(GROW_BYTES)};
			S_MSCAN:  alu_op = '{1'b0, 18'(frd_q.start), 18'(frd_q.len)};
			S_MDEC:   alu_op = '{1'b0, 18'(ins_l_q), 18'(back_len_q)};
			S_FRONT:  alu_op = '{1'b0, 18'(front_len_q), 18'(ins_l_q)};
			S_MERGED: alu_op = '{1'b0, 18'(total_q), 18'(add_q)};
			S_TAKE:   alu_op = '{1'b1, 18'(pick_len_q), 18'(need_q)};
			S_COMMIT: alu_op = '{1'b1, 18'(total_q), 18'(need_q)};
			S_USCAN:  alu_op = '{1'b0, 18'(urd_q.start), 18'(HEADER_BYTES)};
			S_STATS:  alu_op = '{1'b1, 18'(frd_q.len), 18'(HEADER_BYTES)};
			default:  alu_op = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.func == FN_FREE) state_d = S_USCAN;
					else if (req.req_bytes == 16'd0) state_d = S_STATS;
					else state_d = S_SLOT;
				end
			end
			S_SLOT: begin
				if (c_q == CNT_W'(MAX_CHUNKS)) state_d = S_STATS;
				else if (!used_valid_q[c_q[IDX_W-1:0]])
					state_d = (total_q < need_q) ? S_GROW : S_FSCAN;
			end
			S_GROW:   state_d = grow_bad ? S_STATS : S_MSCAN;
			S_MSCAN:  if (scan_end) state_d = S_MDEC;
			S_MDEC: begin
				if (!front_vld_q && !back_vld_q && n_q >= CNT_W'(MAX_CHUNKS))
					state_d = S_STATS;
				else if (back_vld_q) state_d = S_RM_RD;
				else state_d = S_FRONT;
			end
			S_RM_RD: begin
				if (CNT_W'(c_q + 1'b1) >= n_q)
					state_d = (ctx_q == CTX_TAKE) ? S_COMMIT : S_FRONT;
				else state_d = S_RM_WR;
			end
			S_RM_WR:   state_d = S_RM_RD;
			S_FRONT:   state_d = front_vld_q ? S_MERGED : S_PU_RD;
			S_PU_RD:   state_d = (c_q == '0) ? S_PU_HEAD : S_PU_WR;
			S_PU_WR:   state_d = S_PU_RD;
			S_PU_HEAD: state_d = S_MERGED;
			S_MERGED:  state_d = (ctx_q == CTX_GROW) ? S_FSCAN : S_STATS;
			S_FSCAN:   if (scan_end) state_d = pick_vld_q ? S_TAKE : S_STATS;
			S_TAKE:    state_d = (alu_res < 18'(HEADER_BYTES)) ? S_RM_RD : S_COMMIT;
			S_COMMIT:  state_d = S_STATS;
			S_USCAN: begin
				if (u_hit) state_d = S_MSCAN;
				else if (scan_end) state_d = S_STATS;
			end
			S_STATS:   if (scan_end) state_d = S_DONE;
			S_DONE:    if (res_ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs and table port control
	always_comb begin
		req_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
		fra = c_q[IDX_W-1:0];
		ura = c_q[IDX_W-1:0];
		fwe = 1'b0;
		fwa = c_q[IDX_W-1:0];
		fwd = frd_q;
		uwe = 1'b0;
		uwd = '{pick_start_q, need_q};
		unique case (state_q)
			S_RM_RD: fra = IDX_W'(c_q + 1'b1);
			S_RM_WR: fwe = 1'b1;
			S_PU_RD: fra = IDX_W'(c_q - 1'b1);
			S_PU_WR: fwe = 1'b1;
			S_PU_HEAD: begin
				fwe = 1'b1;
				fwa = '0;
				fwd = '{ins_s_q, ins_l_q};
			end
			S_FRONT: begin
				fwe = front_vld_q;
				fwa = front_idx_q;
				fwd = '{front_start_q, alu_res[16:0]};
			end
			S_TAKE: begin
				fwe = (alu_res >= 18'(HEADER_BYTES));
				fwa = pick_idx_q;
				fwd = '{pick_start_q + need_q[15:0], alu_res[16:0]};
			end
			S_COMMIT: uwe = 1'b1;
			default: ;
		endcase
		res.status     = status_q;
		res.granted    = granted_q;
		res.free_bytes = sum_q;
		res.chunks     = cnt_q;
		res.largest    = (cnt_q != '0) ? (lg_q - 17'(HEADER_BYTES)) : '0;
		res.smallest   = (cnt_q != '0) ? (sm_q - 17'(HEADER_BYTES)) : '0;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			n_q          <= '0;
			heap_top_q   <= '0;
			total_q      <= '0;
			used_valid_q <= '0;
			c_q          <= '0;
			pend_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr) begin
				n_q          <= '0;
				heap_top_q   <= '0;
				total_q      <= '0;
				used_valid_q <= '0;
			end
			// every scan starts from entry zero with an empty pipeline
			if (scan_entry) begin
				c_q     <= '0;
				pend_s1 <= 1'b0;
			end else if (scan_state) begin
				pend_s1 <= issue;
				if (issue) c_q <= c_q + 1'b1;
			end else begin
				unique case (state_q)
					S_IDLE:  c_q <= '0;
					S_SLOT:  if (used_valid_q[c_q[IDX_W-1:0]]) c_q <= c_q + 1'b1;
					S_MDEC:  c_q <= CNT_W'(back_idx_q);
					S_RM_WR: c_q <= c_q + 1'b1;
					S_FRONT: c_q <= n_q;
					S_PU_WR: c_q <= c_q - 1'b1;
					S_TAKE:  c_q <= CNT_W'(pick_idx_q);
					default: ;
				endcase
			end
			unique case (state_q)
				S_RM_RD:  if (CNT_W'(c_q + 1'b1) >= n_q) n_q <= n_q - 1'b1;
				S_PU_HEAD: n_q <= n_q + 1'b1;
				S_MERGED: begin
					total_q <= alu_res[16:0];
					if (ctx_q == CTX_GROW) heap_top_q <= sl_q[16:0];
					else used_valid_q[slot_q] <= 1'b0;
				end
				S_COMMIT: begin
					total_q <= alu_res[16:0];
					used_valid_q[slot_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan_state) idx_s1 <= c_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				need_q    <= 17'(HEADER_BYTES) + 17'(req.req_bytes);
				addr_q    <= req.addr;
				granted_q <= '0;
				status_q  <= (req.func != FN_FREE && req.req_bytes == 16'd0) ?
					ST_IGNORED : ST_DONE;
			end
			S_SLOT: begin
				if (c_q == CNT_W'(MAX_CHUNKS)) status_q <= ST_FULL;
				else slot_q <= c_q[IDX_W-1:0];
			end
			S_GROW: begin
				if (grow_bad) status_q <= ST_NO_SPACE;
				ins_s_q <= heap_top_q[15:0];
				ins_l_q <= 17'(GROW_BYTES);
				add_q   <= 17'(GROW_BYTES);
				sl_q    <= alu_res;
				ctx_q   <= CTX_GROW;
			end
			S_MSCAN: begin
				if (m_front) begin
					front_vld_q   <= 1'b1;
					front_idx_q   <= idx_s1;
					front_start_q <= frd_q.start;
					front_len_q   <= frd_q.len;
				end
				if (m_back) begin
					back_vld_q <= 1'b1;
					back_idx_q <= idx_s1;
					back_len_q <= frd_q.len;
				end
			end
			S_MDEC: begin
				if (!front_vld_q && !back_vld_q && n_q >= CNT_W'(MAX_CHUNKS))
					status_q <= ST_FULL;
				if (back_vld_q) begin
					ins_l_q <= alu_res[16:0];
					if (front_vld_q && front_idx_q > back_idx_q)
						front_idx_q <= front_idx_q - 1'b1;
				end
			end
			S_FSCAN: begin
				if (f_take) begin
					pick_vld_q   <= 1'b1;
					pick_idx_q   <= idx_s1;
					pick_start_q <= frd_q.start;
					pick_len_q   <= frd_q.len;
				end
				if (scan_end && !pick_vld_q) status_q <= ST_NO_SPACE;
			end
			S_TAKE: begin
				if (alu_res < 18'(HEADER_BYTES)) begin
					need_q <= pick_len_q;
					ctx_q  <= CTX_TAKE;
				end
			end
			S_COMMIT: granted_q <= pick_start_q + 16'(HEADER_BYTES);
			S_USCAN: begin
				if (u_hit) begin
					slot_q  <= idx_s1;
					ins_s_q <= urd_q.start;
					ins_l_q <= urd_q.len;
					add_q   <= urd_q.len;
					sl_q    <= 18'(urd_q.start) + 18'(urd_q.len);
					ctx_q   <= CTX_FREE;
				end else if (scan_end) status_q <= ST_IGNORED;
			end
			S_STATS: begin
				if (s_ok) begin
					sum_q <= sum_q + alu_res[16:0];
					cnt_q <= cnt_q + 1'b1;
					if (frd_q.len > lg_q) lg_q <= frd_q.len;
					if (sm_q == '0 || frd_q.len < sm_q) sm_q <= frd_q.len;
				end
			end
			default: ;
		endcase
		if (state_d == S_MSCAN && state_q != S_MSCAN) begin
			front_vld_q <= 1'b0;
			back_vld_q  <= 1'b0;
		end
		if (state_d == S_FSCAN && state_q != S_FSCAN) pick_vld_q <= 1'b0;
		if (state_d == S_STATS && state_q != S_STATS) begin
			sum_q <= '0;
			cnt_q <= '0;
			lg_q  <= '0;
			sm_q  <= '0;
		end
	end

	a_entries: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_CHUNKS))
		else $error("free table count beyond capacity");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= heap_top_q)
		else $error("free bytes exceed heap size");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		heap_top_q <= limit)
		else $error("heap grew beyond its limit");

	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |=> used_valid_q[$past(slot_q)])
		else $error("granted block not marked in use");

endmodule

[hdl/fit_policy_heap_allocator.sv]
// top level of the fit-policy heap allocator: register port, request and result channels
// a zero-size alloc only runs the statistics scan over the free chunks; the longest path is an
// alloc that searches all used slots, grows the heap and shifts a full free table
// throughput: one request at a time; the shared adder and single-port chunk tables are swept
// several times per request, and the result waits in an output register
// reset: asynchronous, clears heap and both registers; any register write also empties the heap
module fit_policy_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] request_bytes,
	input  logic [15:0] payload_address,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] granted_address,
	output logic [16:0] free_payload_bytes,
	output logic [6:0]  free_chunk_count,
	output logic [16:0] largest_free,
	output logic [16:0] smallest_free
);
	import fph_pkg::*;

	logic [1:0]  policy_q;
	logic [16:0] limit_q;
	logic        cfg_wr;

	request_t req;
	result_t  res, out_q;
	logic     req_ready, res_valid, res_ready, out_valid_q;

	// register writes complete in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit_q) : 32'(policy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			limit_q  <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_POLICY) policy_q <= pwdata[1:0];
			else limit_q <= pwdata[16:0];
		end
	end

	// request accepted only while the sequencer is idle
	assign req      = '{func, request_bytes, payload_address};
	assign in_stall = !req_ready;

	fph_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_wr),
		.policy    (policy_q),
		.limit     (limit_q),
		.req_valid (in_valid),
		.req       (req),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register decouples the result from downstream stalls
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid          = out_valid_q;
	assign status             = out_q.status;
	assign granted_address    = out_q.granted;
	assign free_payload_bytes = out_q.free_bytes;
	assign free_chunk_count   = out_q.chunks;
	assign largest_free       = out_q.largest;
	assign smallest_free      = out_q.smallest;

endmodule

[verif/tb.sv]
// testbench of the fit-policy heap allocator: queued driver, predictor, result monitor
module tb;
	import fph_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic        func;
	logic [15:0] request_bytes, payload_address;
	logic        out_valid, out_stall;
	logic [1:0]  status;
	logic [15:0] granted_address;
	logic [16:0] free_payload_bytes;
	logic [6:0]  free_chunk_count;
	logic [16:0] largest_free, smallest_free;

	fit_policy_heap_allocator u_dut (.*);

	// predictor state
	logic [1:0]  pol;
	logic [16:0] lim;
	int unsigned fr_s [MAX_CHUNKS];
	int unsigned fr_l [MAX_CHUNKS];
	int unsigned fr_n;
	int unsigned us_s [MAX_CHUNKS];
	int unsigned us_l [MAX_CHUNKS];
	bit          us_v [MAX_CHUNKS];
	int unsigned top_b, free_tot;

	request_t req_q [$];
	result_t  want_q [$];
	// granted payload addresses the stimulus may free
	int unsigned live_q [$];
	int          errors;
	longint      cycles;
	bit          drv_hold;
	// request taken at the last rising edge
	bit          in_acc;

	function automatic void heap_clear();
		fr_n = 0; top_b = 0; free_tot = 0;
		for (int k = 0; k < MAX_CHUNKS; k++) us_v[k] = 0;
	endfunction

	function automatic void chunk_remove(int unsigned i);
		for (int unsigned k = i; k + 1 < fr_n; k++) begin
			fr_s[k] = fr_s[k+1]; fr_l[k] = fr_l[k+1];
		end
		fr_n--;
	endfunction

	function automatic bit chunk_insert(int unsigned s, int unsigned l);
		int front, back;
		front = -1; back = -1;
		for (int k = 0; k < fr_n; k++) begin
			if (fr_s[k] + fr_l[k] == s) front = k;
			else if (fr_s[k] == s + l) back = k;
		end
		if (front < 0 && back < 0 && fr_n >= MAX_CHUNKS) return 0;
		if (back >= 0) begin
			l += fr_l[back];
			chunk_remove(back);
			if (front > back) front--;
		end
		if (front >= 0) fr_l[front] += l;
		else begin
			for (int k = fr_n; k > 0; k--) begin
				fr_s[k] = fr_s[k-1]; fr_l[k] = fr_l[k-1];
			end
			fr_s[0] = s; fr_l[0] = l; fr_n++;
		end
		return 1;
	endfunction

	function automatic int fit_search(int unsigned need);
		int pick;
		int unsigned pl;
		pick = -1; pl = 0;
		for (int k = 0; k < fr_n; k++) begin
			if (fr_l[k] < need) continue;
			if (pol == POL_FIRST) return k;
			if (pick < 0 || (pol == POL_BEST && fr_l[k] < pl) ||
			    (pol != POL_BEST && fr_l[k] > pl)) begin
				pick = k; pl = fr_l[k];
			end
		end
		return pick;
	endfunction

	function automatic status_t alloc_model(int unsigned rq, output int unsigned g);
		int unsigned need, slot, len, s, t;
		int idx;
		need = HEADER_BYTES + rq; g = 0;
		if (rq == 0) return ST_IGNORED;
		slot = MAX_CHUNKS;
		for (int k = MAX_CHUNKS - 1; k >= 0; k--) if (!us_v[k]) slot = k;
		if (slot >= MAX_CHUNKS) return ST_FULL;
		if (free_tot < need) begin
			t = top_b + GROW_BYTES;
			if (t > lim || t > ARENA_BYTES) return ST_NO_SPACE;
			if (!chunk_insert(top_b, GROW_BYTES)) return ST_FULL;
			top_b = t; free_tot += GROW_BYTES;
		end
		idx = fit_search(need);
		if (idx < 0) return ST_NO_SPACE;
		s = fr_s[idx]; len = fr_l[idx];
		if (len - need < HEADER_BYTES) begin
			chunk_remove(idx); need = len;
		end else begin
			fr_s[idx] = s + need; fr_l[idx] = len - need;
		end
		free_tot -= need;
		us_v[slot] = 1; us_s[slot] = s; us_l[slot] = need;
		g = (s + HEADER_BYTES) & 16'hFFFF;
		return ST_DONE;
	endfunction

	function automatic status_t free_model(int unsigned a);
		for (int k = 0; k < MAX_CHUNKS; k++)
			if (us_v[k] && ((us_s[k] + HEADER_BYTES) & 16'hFFFF) == a) begin
				if (!chunk_insert(us_s[k], us_l[k])) return ST_FULL;
				us_v[k] = 0; free_tot += us_l[k];
				return ST_DONE;
			end
		return ST_IGNORED;
	endfunction

	function automatic result_t heap_predict(request_t r);
		result_t o;
		int unsigned g, sum, n, big, sml;
		o.status = r.func == FN_FREE ? free_model(r.addr) : alloc_model(r.req_bytes, g);
		if (r.func == FN_FREE || o.status != ST_DONE) g = 0;
		else live_q.push_back(g);
		sum = 0; n = 0; big = 0; sml = 0;
		for (int k = 0; k < fr_n; k++) begin
			if (fr_l[k] < HEADER_BYTES) continue;
			sum += fr_l[k] - HEADER_BYTES; n++;
			if (fr_l[k] > big) big = fr_l[k];
			if (sml == 0 || fr_l[k] < sml) sml = fr_l[k];
		end
		o.granted = 16'(g); o.free_bytes = 17'(sum); o.chunks = 7'(n);
		o.largest = n ? 17'(big - HEADER_BYTES) : 17'd0;
		o.smallest = n ? 17'(sml - HEADER_BYTES) : 17'd0;
		return o;
	endfunction

	// gap length, mostly short and now and then long
	function automatic int unsigned gap_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("fit_policy_heap_allocator verification failed");
			$finish;
		end
	end

	// driver: pops pending requests at the falling edge
	int unsigned drv_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_acc) begin
				in_valid <= 0;
			end else if (!in_valid) begin
				if (drv_gap > 0) drv_gap <= drv_gap - 1;
				else if (!drv_hold && req_q.size() > 0) begin
					request_t r;
					r = req_q.pop_front();
					func <= r.func; request_bytes <= r.req_bytes;
					payload_address <= r.addr;
					in_valid <= 1;
					drv_gap <= gap_len();
				end
			end
		end
	end

	// predict at acceptance; the stall value was set before this edge
	always @(posedge clk) begin
		in_acc = arst_n && in_valid && !in_stall;
		if (in_acc) begin
			request_t r;
			r.func = func; r.req_bytes = request_bytes; r.addr = payload_address;
			want_q.push_back(heap_predict(r));
		end
	end

	// receiver stall at random
	int unsigned rx_gap;
	always @(negedge clk) begin
		if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1; out_stall <= 1;
		end else begin
			out_stall <= 0; rx_gap <= gap_len();
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result status %0d", $time, status);
				errors++;
			end else begin
				result_t w;
				w = want_q.pop_front();
				if (status !== w.status || granted_address !== w.granted ||
				    free_payload_bytes !== w.free_bytes || free_chunk_count !== w.chunks ||
				    largest_free !== w.largest || smallest_free !== w.smallest) begin
					$display("%0t: expected st %0d g %0h fb %0d n %0d lg %0d sm %0d", $time,
					         w.status, w.granted, w.free_bytes, w.chunks, w.largest, w.smallest);
					$display("%0t: actual   st %0d g %0h fb %0d n %0d lg %0d sm %0d", $time,
					         status, granted_address, free_payload_bytes, free_chunk_count,
					         largest_free, smallest_free);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(logic idx, logic [31:0] d);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= d;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_POLICY) pol = d[1:0];
		else lim = d[16:0];
		heap_clear();
		live_q.delete();
	endtask

	task automatic wait_idle();
		while (req_q.size() > 0 || in_valid || want_q.size() > 0) @(negedge clk);
		repeat (700) @(negedge clk);
	endtask

	task automatic push_req(logic f, logic [15:0] b, logic [15:0] a);
		request_t r;
		r.func = f; r.req_bytes = b; r.addr = a;
		req_q.push_back(r);
	endtask

	// random mix: mostly sized allocs and frees of live blocks
	task automatic random_phase(int n);
		int unsigned p, i;
		for (int k = 0; k < n; k++) begin
			while (req_q.size() > 4) @(negedge clk);
			p = $urandom_range(0, 99);
			if (p < 45) push_req(FN_ALLOC, 16'($urandom_range(1, 300)), 16'($urandom()));
			else if (p < 52)
				push_req(FN_ALLOC, 16'($urandom_range(1, 65535)), 16'($urandom()));
			else if (p < 55) push_req(FN_ALLOC, p[0] ? 16'd0 : 16'hFFFF, 16'($urandom()));
			else if (p < 90 && live_q.size() > 0) begin
				i = $urandom_range(0, live_q.size() - 1);
				push_req(FN_FREE, 16'($urandom()), 16'(live_q[i]));
				live_q.delete(i);
			end else push_req(FN_FREE, 16'($urandom()), 16'($urandom()));
		end
	endtask

	initial begin
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; func = 0; request_bytes = 0; payload_address = 0; out_stall = 0;
		errors = 0; cycles = 0; drv_gap = 0; rx_gap = 0; drv_hold = 0; in_acc = 0;
		pol = POL_FIRST; lim = 0; heap_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// zero limit: nothing can grow
		push_req(FN_ALLOC, 16'd1, 16'd0);
		push_req(FN_ALLOC, 16'd0, 16'hFFFF);
		push_req(FN_FREE, 16'hFFFF, 16'hFFFF);
		wait_idle();

		// directed: grow, small remainder, oversized alloc, frees and merges
		reg_write(REG_LIMIT, 32'h10000);
		push_req(FN_ALLOC, 16'd4080, 16'd0);
		push_req(FN_ALLOC, 16'd4065, 16'd0);
		push_req(FN_ALLOC, 16'd100, 16'd0);
		push_req(FN_ALLOC, 16'd200, 16'd0);
		push_req(FN_FREE, 16'd0, 16'd16);
		push_req(FN_FREE, 16'd0, 16'd4112);
		push_req(FN_FREE, 16'd0, 16'd4112);
		push_req(FN_ALLOC, 16'hFFFF, 16'd0);
		push_req(FN_ALLOC, 16'd4096, 16'd0);
		push_req(FN_FREE, 16'd0, 16'd3);
		wait_idle();

		// sender holds off until every result is in
		push_req(FN_ALLOC, 16'd50, 16'd0);
		push_req(FN_ALLOC, 16'd70, 16'd0);
		while (req_q.size() > 0) @(negedge clk);
		drv_hold = 1;
		push_req(FN_ALLOC, 16'd90, 16'd0);
		while (in_valid || want_q.size() > 0) @(negedge clk);
		drv_hold = 0;
		wait_idle();

		// used table full: many tiny allocs
		reg_write(REG_POLICY, 32'(POL_BEST));
		for (int k = 0; k < 66; k++) push_req(FN_ALLOC, 16'd1, 16'd0);
		wait_idle();
		random_phase(100);
		wait_idle();

		reg_write(REG_POLICY, 32'(POL_WORST));
		reg_write(REG_LIMIT, 32'd8192);
		random_phase(100);
		wait_idle();

		// unassigned policy code behaves as worst fit
		reg_write(REG_POLICY, 32'd3);
		reg_write(REG_LIMIT, 32'h1FFFF);
		random_phase(100);
		wait_idle();

		reg_write(REG_POLICY, 32'(POL_FIRST));
		reg_write(REG_LIMIT, 32'h10000);
		random_phase(150);
		wait_idle();

		if (errors == 0) $display("fit_policy_heap_allocator verification clean");
		else $display("fit_policy_heap_allocator verification failed");
		$finish;
	end
endmodule
